/* hdl/ipct_pkg.sv */
// Shared types and constants for the IR pattern carrier timing unit.
package ipct_pkg;

  // Configuration register indexes
  localparam logic [1:0] RegSpiBitRate = 2'd0;
  localparam logic [1:0] RegCarrier    = 2'd1;
  localparam logic [1:0] RegCapacity   = 2'd2;

  // Field widths
  localparam int unsigned SpiW    = 24;
  localparam int unsigned CarW    = 17;
  localparam int unsigned CapW    = 22;
  localparam int unsigned DurW    = 24;
  localparam int unsigned CycW    = 28;
  localparam int unsigned HalfW   = 10;
  localparam int unsigned ExtraW  = 12;
  localparam int unsigned TotalW  = 25;
  localparam int unsigned BpW     = 7;
  localparam int unsigned CpW     = 11;
  localparam int unsigned SampW   = 11;
  localparam int unsigned PeriodW = BpW + SampW;
  localparam int unsigned ResW    = 16;
  localparam int unsigned ProdW   = CycW + SampW;
  localparam int unsigned SumW    = ProdW + 1;

  // Shared divider geometry
  localparam int unsigned DivQW   = 28;
  localparam int unsigned DivRW   = 24;
  localparam int unsigned DivCntW = $clog2(DivQW);

  // Arithmetic constants
  localparam logic [DivQW-1:0] TenMhzTenths = 28'd10000000;
  localparam logic [BpW-1:0]   BpMax        = 7'd127;
  localparam logic [CpW-1:0]   CpMax        = 11'd2047;
  localparam logic [SampW-1:0] SampMax      = 11'd2046;

  // Reset values of registers and derived timing
  localparam logic [SpiW-1:0]    SpiReset    = 24'd5000000;
  localparam logic [CarW-1:0]    CarReset    = 17'd38000;
  localparam logic [CapW-1:0]    CapReset    = 22'd2097152;
  localparam logic [BpW-1:0]     BpReset     = 7'd2;
  localparam logic [CpW-1:0]     CpReset     = 11'd263;
  localparam logic [HalfW-1:0]   HighReset   = 10'd66;
  localparam logic [HalfW-1:0]   LowReset    = 10'd66;
  localparam logic [PeriodW-1:0] PeriodReset = 18'd264;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CFG,
    ST_BP_DIV,
    ST_CP_DIV,
    ST_RATIO_START,
    ST_RATIO_DIV,
    ST_PERIOD,
    ST_ITEM,
    ST_CYC_DIV,
    ST_EXTRA_DIV,
    ST_ACC_MUL,
    ST_ACC_SUM
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DivQW-1:0] dividend;
    logic [DivRW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivQW-1:0] quotient;
    logic [DivRW-1:0] remainder;
  } div_rsp_t;

endpackage

/* hdl/ipct_div.sv */
// Restoring divider, one quotient bit per cycle.
module ipct_div (
  input  logic               clk,
  input  logic               rst,
  input  ipct_pkg::div_req_t req,
  output ipct_pkg::div_rsp_t rsp
);

  logic [ipct_pkg::DivQW-1:0]   quo;
  logic [ipct_pkg::DivRW-1:0]   rem;
  logic [ipct_pkg::DivRW-1:0]   dvs;
  logic [ipct_pkg::DivCntW-1:0] cnt;
  logic                         busy;
  logic                         done;

  logic [ipct_pkg::DivRW:0]     trial;
  logic                         fits;
  logic [ipct_pkg::DivRW:0]     diff;

  assign trial = {rem, quo[ipct_pkg::DivQW-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[ipct_pkg::DivQW-2:0], fits};
        rem <= fits ? diff[ipct_pkg::DivRW-1:0] : trial[ipct_pkg::DivRW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == ipct_pkg::DivCntW'(ipct_pkg::DivQW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* hdl/ir_pattern_carrier_timing_unit.sv */
// Top level of the IR pattern carrier timing unit: sequencer around one shared divider.
//
//  channel | handshake           | beat contents
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid / in_stall | duration_us, last
//  out     | out_valid/out_stall | is_mark, carrier_cycles, high_bits, low_bits,
//          |                     | extra_low_bits, bits_total, truncated, last_out
//  cfg     | cfg_valid/cfg_ready | cfg_index (0 bit rate, 1 carrier, 2 capacity), cfg_data
//
// A mark takes one pass through the 28-bit restoring divider and the next beat is taken
// once its result is loaded; a space needs a second divider pass for its extra low bits.
// A register write rederives the timing with three divider passes, during
// which neither input nor configuration is taken.
// Reset loads the default registers and their precomputed timing, so no derivation runs.
// The result register lets the next beat in while an earlier result is still stalled;
// only the final accumulate step waits for it to drain.
module ir_pattern_carrier_timing_unit (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ipct_pkg::DurW-1:0]      duration_us,
  input  logic                           last,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           is_mark,
  output logic [ipct_pkg::CycW-1:0]      carrier_cycles,
  output logic [ipct_pkg::HalfW-1:0]     high_bits,
  output logic [ipct_pkg::HalfW-1:0]     low_bits,
  output logic [ipct_pkg::ExtraW-1:0]    extra_low_bits,
  output logic [ipct_pkg::TotalW-1:0]    bits_total,
  output logic                           truncated,
  output logic                           last_out,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [ipct_pkg::SpiW-1:0]      cfg_data
);

  ipct_pkg::state_t state, state_next;

  // Configuration registers
  logic [ipct_pkg::SpiW-1:0]    spi_bit_rate_hz;
  logic [ipct_pkg::CarW-1:0]    carrier_hz;
  logic [ipct_pkg::CapW-1:0]    capacity_bytes;

  // Derived timing
  logic [ipct_pkg::BpW-1:0]     bit_period;
  logic [ipct_pkg::CpW-1:0]     carrier_period;
  logic [ipct_pkg::HalfW-1:0]   high_count;
  logic [ipct_pkg::HalfW-1:0]   low_count;
  logic [ipct_pkg::PeriodW-1:0] period;

  // Sequence state
  logic [ipct_pkg::ResW-1:0]    residual;
  logic                         odd_position;
  logic [ipct_pkg::TotalW-1:0]  bit_count;

  // Working registers of the item in flight
  logic [ipct_pkg::DurW-1:0]    dur;
  logic                         last_r;
  logic [ipct_pkg::CycW-1:0]    cycles;
  logic [ipct_pkg::ResW-1:0]    left;
  logic [ipct_pkg::ExtraW-1:0]  extra;
  logic [ipct_pkg::ProdW-1:0]   add_prod;

  ipct_pkg::div_req_t div_req;
  ipct_pkg::div_rsp_t div_rsp;

  logic                         cfg_write;
  logic                         in_take;
  logic                         out_free;
  logic                         ld_out;

  logic [ipct_pkg::DivQW-1:0]   q;
  logic [ipct_pkg::DivRW-1:0]   r;
  logic [ipct_pkg::BpW-1:0]     bp_val;
  logic [ipct_pkg::CpW-1:0]     cp_val;
  logic [ipct_pkg::SampW-1:0]   n_val;
  logic [ipct_pkg::SampW-1:0]   samples;
  logic [ipct_pkg::DivQW-1:0]   p_val;
  logic [ipct_pkg::PeriodW:0]   mark_left;
  logic [ipct_pkg::ResW-1:0]    mark_left_sat;
  logic [ipct_pkg::SumW-1:0]    sum;
  logic [ipct_pkg::TotalW-1:0]  cap_bits;
  logic                         trunc;
  logic [ipct_pkg::TotalW-1:0]  sum_sat;

  ipct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign q = div_rsp.quotient;
  assign r = div_rsp.remainder;

  // Clamping of divider results into the timing registers
  always_comb begin
    if (spi_bit_rate_hz == '0) begin
      bp_val = ipct_pkg::BpMax;
    end else if (q == '0) begin
      bp_val = ipct_pkg::BpW'(1);
    end else if (q > ipct_pkg::DivQW'(ipct_pkg::BpMax)) begin
      bp_val = ipct_pkg::BpMax;
    end else begin
      bp_val = q[ipct_pkg::BpW-1:0];
    end

    if (carrier_hz == '0) begin
      cp_val = ipct_pkg::CpMax;
    end else if (q > ipct_pkg::DivQW'(ipct_pkg::CpMax)) begin
      cp_val = ipct_pkg::CpMax;
    end else begin
      cp_val = q[ipct_pkg::CpW-1:0];
    end

    if (q == '0) begin
      n_val = ipct_pkg::SampW'(1);
    end else if (q > ipct_pkg::DivQW'(ipct_pkg::SampMax)) begin
      n_val = ipct_pkg::SampMax;
    end else begin
      n_val = q[ipct_pkg::SampW-1:0];
    end
  end

  assign samples = {1'b0, high_count} + {1'b0, low_count};

  // Time to divide: duration in tenths, plus the carried remainder for a space
  assign p_val = ipct_pkg::DivQW'(dur) * ipct_pkg::DivQW'(10)
               + (odd_position ? ipct_pkg::DivQW'(residual) : '0);

  // After a mark the remainder is added to what is already carried
  assign mark_left     = (ipct_pkg::PeriodW+1)'(residual)
                       + (ipct_pkg::PeriodW+1)'(r[ipct_pkg::PeriodW-1:0]);
  assign mark_left_sat = (mark_left > (ipct_pkg::PeriodW+1)'({ipct_pkg::ResW{1'b1}}))
                       ? {ipct_pkg::ResW{1'b1}} : mark_left[ipct_pkg::ResW-1:0];

  // Running total with saturation at the buffer size
  assign sum      = ipct_pkg::SumW'(bit_count) + ipct_pkg::SumW'(add_prod)
                  + ipct_pkg::SumW'(extra);
  assign cap_bits = {capacity_bytes, 3'b000};
  assign trunc    = sum > ipct_pkg::SumW'(cap_bits);
  assign sum_sat  = trunc ? cap_bits : sum[ipct_pkg::TotalW-1:0];

  assign cfg_write = cfg_valid && cfg_ready;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ipct_pkg::ST_IDLE: begin
        if (cfg_write) begin
          state_next = ipct_pkg::ST_CFG;
        end else if (in_take) begin
          state_next = ipct_pkg::ST_ITEM;
        end
      end
      ipct_pkg::ST_CFG:       state_next = ipct_pkg::ST_BP_DIV;
      ipct_pkg::ST_BP_DIV: begin
        if (div_rsp.done) state_next = ipct_pkg::ST_CP_DIV;
      end
      ipct_pkg::ST_CP_DIV: begin
        if (div_rsp.done) state_next = ipct_pkg::ST_RATIO_START;
      end
      ipct_pkg::ST_RATIO_START: state_next = ipct_pkg::ST_RATIO_DIV;
      ipct_pkg::ST_RATIO_DIV: begin
        if (div_rsp.done) state_next = ipct_pkg::ST_PERIOD;
      end
      ipct_pkg::ST_PERIOD:    state_next = ipct_pkg::ST_IDLE;
      ipct_pkg::ST_ITEM:      state_next = ipct_pkg::ST_CYC_DIV;
      ipct_pkg::ST_CYC_DIV: begin
        if (div_rsp.done) begin
          state_next = odd_position ? ipct_pkg::ST_EXTRA_DIV : ipct_pkg::ST_ACC_MUL;
        end
      end
      ipct_pkg::ST_EXTRA_DIV: begin
        if (div_rsp.done) state_next = ipct_pkg::ST_ACC_MUL;
      end
      ipct_pkg::ST_ACC_MUL:   state_next = ipct_pkg::ST_ACC_SUM;
      ipct_pkg::ST_ACC_SUM: begin
        if (out_free) state_next = ipct_pkg::ST_IDLE;
      end
      default:                state_next = ipct_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes and divider launches
  always_comb begin
    cfg_ready        = (state == ipct_pkg::ST_IDLE);
    in_stall         = (state != ipct_pkg::ST_IDLE) || cfg_valid;
    ld_out           = (state == ipct_pkg::ST_ACC_SUM) && out_free;
    div_req.start    = 1'b0;
    div_req.dividend = ipct_pkg::TenMhzTenths;
    div_req.divisor  = ipct_pkg::DivRW'(spi_bit_rate_hz);
    unique case (state)
      ipct_pkg::ST_CFG: begin
        div_req.start = 1'b1;
      end
      ipct_pkg::ST_BP_DIV: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = ipct_pkg::DivRW'(carrier_hz);
      end
      ipct_pkg::ST_RATIO_START: begin
        // (2cp + bp) / 2bp: cp/bp rounded to the nearest whole sample in one pass
        div_req.start    = 1'b1;
        div_req.dividend = ipct_pkg::DivQW'({carrier_period, 1'b0})
                         + ipct_pkg::DivQW'(bit_period);
        div_req.divisor  = ipct_pkg::DivRW'({bit_period, 1'b0});
      end
      ipct_pkg::ST_ITEM: begin
        div_req.start    = 1'b1;
        div_req.dividend = p_val;
        div_req.divisor  = ipct_pkg::DivRW'(period);
      end
      ipct_pkg::ST_CYC_DIV: begin
        div_req.start    = div_rsp.done && odd_position;
        div_req.dividend = ipct_pkg::DivQW'(r[ipct_pkg::PeriodW-1:0]);
        div_req.divisor  = ipct_pkg::DivRW'(bit_period);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ipct_pkg::ST_IDLE;
      spi_bit_rate_hz <= ipct_pkg::SpiReset;
      carrier_hz      <= ipct_pkg::CarReset;
      capacity_bytes  <= ipct_pkg::CapReset;
      bit_period      <= ipct_pkg::BpReset;
      carrier_period  <= ipct_pkg::CpReset;
      high_count      <= ipct_pkg::HighReset;
      low_count       <= ipct_pkg::LowReset;
      period          <= ipct_pkg::PeriodReset;
      residual        <= '0;
      odd_position    <= 1'b0;
      bit_count       <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          ipct_pkg::RegSpiBitRate: spi_bit_rate_hz <= cfg_data;
          ipct_pkg::RegCarrier:    carrier_hz      <= cfg_data[ipct_pkg::CarW-1:0];
          ipct_pkg::RegCapacity:   capacity_bytes  <= cfg_data[ipct_pkg::CapW-1:0];
          default:                 ;
        endcase
      end

      if (state == ipct_pkg::ST_BP_DIV && div_rsp.done) bit_period <= bp_val;
      if (state == ipct_pkg::ST_CP_DIV && div_rsp.done) carrier_period <= cp_val;
      if (state == ipct_pkg::ST_RATIO_DIV && div_rsp.done) begin
        high_count <= n_val[ipct_pkg::SampW-1:1];
        low_count  <= n_val[ipct_pkg::SampW-1:1] + ipct_pkg::HalfW'(n_val[0]);
      end
      if (state == ipct_pkg::ST_PERIOD) begin
        period <= ipct_pkg::PeriodW'(samples) * ipct_pkg::PeriodW'(bit_period);
      end

      if (ld_out) begin
        residual     <= last_r ? '0 : left;
        bit_count    <= last_r ? '0 : sum_sat;
        odd_position <= last_r ? 1'b0 : !odd_position;
        out_valid    <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      dur    <= duration_us;
      last_r <= last;
    end
    if (state == ipct_pkg::ST_CYC_DIV && div_rsp.done) begin
      cycles <= q;
      if (!odd_position) begin
        left  <= mark_left_sat;
        extra <= '0;
      end
    end
    if (state == ipct_pkg::ST_EXTRA_DIV && div_rsp.done) begin
      extra <= q[ipct_pkg::ExtraW-1:0];
      left  <= ipct_pkg::ResW'(r[ipct_pkg::BpW-1:0]);
    end
    if (state == ipct_pkg::ST_ACC_MUL) begin
      add_prod <= ipct_pkg::ProdW'(cycles) * ipct_pkg::ProdW'(samples);
    end
    if (ld_out) begin
      is_mark        <= !odd_position;
      carrier_cycles <= cycles;
      high_bits      <= high_count;
      low_bits       <= low_count;
      extra_low_bits <= extra;
      bits_total     <= sum_sat;
      truncated      <= trunc;
      last_out       <= last_r;
    end
  end

endmodule
